>>> sv/htrd_pkg.sv
// Shared types, widths and codes for the hex torus ray distance block.
// No dependencies; every other file depends on this package.
package htrd_pkg;

  // Storage bounds of the cell grid
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CELLS  = MAX_ROWS * MAX_COLS;

  // Grid dimension registers hold 1..MAX
  localparam int DIM_W  = 7;
  localparam int TYPE_W = 2;
  localparam int SIDE_W = 3;
  localparam int DIST_W = 6;

  // Remainder unit: one quotient bit per cycle
  localparam int MOD_STEPS = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int MODCNT_W  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // Register map
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Cell types
  localparam logic [TYPE_W-1:0] TYPE_EMPTY = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_EDGE  = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_NODE  = 2'd2;

  // Grid size as seen by the walker
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } grid_cfg_t;

  // Cell memory request from the walker
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [TYPE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

endpackage

>>> sv/htrd_in_if.sv
// Input item channel: valid/ready handshake plus write or query payload.
// Depends on htrd_pkg for field widths.
interface htrd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [htrd_pkg::ROW_W-1:0]  row;
  logic [htrd_pkg::COL_W-1:0]  col;
  logic [htrd_pkg::SIDE_W-1:0] side;
  logic [htrd_pkg::TYPE_W-1:0] cell_type;

  modport source (output valid, op, row, col, side, cell_type, input ready);
  modport sink   (input valid, op, row, col, side, cell_type, output ready);
endinterface

>>> sv/htrd_out_if.sv
// Result channel: valid/ready handshake plus neighbour and distance payload.
// Depends on htrd_pkg for field widths.
interface htrd_out_if;
  logic                        valid;
  logic                        ready;
  logic [htrd_pkg::ROW_W-1:0]  next_row;
  logic [htrd_pkg::COL_W-1:0]  next_col;
  logic [htrd_pkg::TYPE_W-1:0] neighbour_type;
  logic [htrd_pkg::DIST_W-1:0] node_distance;

  modport source (output valid, next_row, next_col, neighbour_type, node_distance,
                  input ready);
  modport sink   (input valid, next_row, next_col, neighbour_type, node_distance,
                  output ready);
endinterface

>>> sv/hex_torus_ray_distance_top.sv
// Hex torus ray distance block: register file, cell memory and walker.
// Depends on htrd_pkg, htrd_in_if, htrd_out_if and the htrd_* modules.
//
// Usage:
//   in_ch carries items. A write (op 0) stores cell_type at (row, col) and
//   gives no result. A query (op 1) names a cell and a side and returns
//   one transfer on out_ch: the wrapped neighbour, its type and the step
//   count to the first node along that side (0 if an empty cell comes first
//   or none is met within grid_rows-1 steps).
//   A query first reduces row/col by the grid size, then sets up the ray in
//   S_HOP and S_PRIME, then walks the ray cell by cell, issuing the next
//   cell's address while the previous read returns, and then loads the
//   result register.
//   in_ch.ready is high only while no query is in progress.
//   If out_ch stalls, a finished result waits in the output register; the
//   next item is still taken, and a second query holds at its end until the
//   result register frees.
//   Reset returns grid_rows and grid_cols to 64; the cell memory is not
//   cleared, so cells must be written before they are queried.
//   cfg_* is an APB-style port; rows at address 0, columns at address 4.
module hex_torus_ray_distance_top (
  input  logic        clk,
  input  logic        rst_n,
  htrd_in_if.sink     in_ch,
  htrd_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import htrd_pkg::*;

  grid_cfg_t         grid_cfg;
  ram_req_t          ram_req;
  logic [TYPE_W-1:0] ram_rd_data;
  logic              busy;

  htrd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .grid_cfg    (grid_cfg)
  );

  htrd_cell_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  htrd_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_cfg    (grid_cfg),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .busy        (busy)
  );

  // Writes and ray reads never share a cycle on the memory
  a_ram_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.wr_en && ram_req.rd_en))
    else $error("cell memory read and write in the same cycle");

  // The memory is written only by an accepted write item
  a_wr_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> (in_ch.valid && in_ch.ready && (in_ch.op == OP_WRITE)))
    else $error("cell memory written without a write transfer");

  // An accepted query always starts the sequencer
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.op == OP_QUERY)) |=> busy)
    else $error("query transfer did not start a walk");

endmodule

>>> sv/htrd_cfg_regs.sv
// APB-style register file for the grid dimensions, with clamping on write.
// Depends on htrd_pkg.
module htrd_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output htrd_pkg::grid_cfg_t       grid_cfg
);
  import htrd_pkg::*;

  logic [DIM_W-1:0] rows_r, rows_nxt;
  logic [DIM_W-1:0] cols_r, cols_nxt;
  logic             wr_hit;
  logic             reg_sel;

  // 0 reads as 1, anything above the storage bound saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) res = DIM_W'(1);
    else if (v > maxv) res = maxv;
    else res = v;
    return res;
  endfunction

  assign cfg_pready = 1'b1;
  assign wr_hit     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  // Next values on a write transfer
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (wr_hit) begin
      case (reg_sel)
        REG_GRID_ROWS: rows_nxt = clamp_dim(cfg_pwdata[DIM_W-1:0], DIM_W'(MAX_ROWS));
        REG_GRID_COLS: cols_nxt = clamp_dim(cfg_pwdata[DIM_W-1:0], DIM_W'(MAX_COLS));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(MAX_ROWS);
      cols_r <= DIM_W'(MAX_COLS);
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_GRID_ROWS: cfg_prdata = {{(32-DIM_W){1'b0}}, rows_r};
      REG_GRID_COLS: cfg_prdata = {{(32-DIM_W){1'b0}}, cols_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign grid_cfg.rows = rows_r;
  assign grid_cfg.cols = cols_r;

endmodule

>>> sv/htrd_cell_ram.sv
// Cell type memory: one write port, one read port, registered read data.
// Depends on htrd_pkg.
module htrd_cell_ram (
  input  logic                         clk,
  input  htrd_pkg::ram_req_t           req,
  output logic [htrd_pkg::TYPE_W-1:0]  rd_data
);
  import htrd_pkg::*;

  logic [TYPE_W-1:0] mem [CELLS];
  logic [TYPE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/htrd_walker.sv
// Item sequencer: stores writes, reduces query coordinates, walks the ray
// through the cell memory and holds the result register.
// Depends on htrd_pkg, htrd_in_if and htrd_out_if.
module htrd_walker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  htrd_pkg::grid_cfg_t          grid_cfg,
  htrd_in_if.sink                      in_ch,
  htrd_out_if.source                   out_ch,
  output htrd_pkg::ram_req_t           ram_req,
  input  logic [htrd_pkg::TYPE_W-1:0]  ram_rd_data,
  output logic                         busy
);
  import htrd_pkg::*;

  // Hexagon sides
  localparam logic [SIDE_W-1:0] SIDE_LEFT  = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_UP_L  = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_UP_R  = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_DN_R  = 3'd4;
  localparam logic [SIDE_W-1:0] SIDE_DN_L  = 3'd5;

  localparam int SH_W = DIM_W + MOD_STEPS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_HOP   = 6'b000100,
    S_PRIME = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } walk_state_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_pos_t;

  walk_state_t       state_r, state_nxt;
  logic [MODCNT_W-1:0] mod_cnt_r, mod_cnt_nxt;
  cell_pos_t         qpos_r, qpos_nxt;     // query cell, reduced in place
  logic [SIDE_W-1:0] side_r, side_nxt;
  cell_pos_t         npos_r, npos_nxt;     // neighbour cell
  cell_pos_t         wpos_r, wpos_nxt;     // next cell to read
  logic [DIM_W-1:0]  step_r, step_nxt;     // step number of the data in flight
  logic              first_r, first_nxt;
  logic [TYPE_W-1:0] nb_type_r, nb_type_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  logic              out_valid_r;
  cell_pos_t         out_pos_r;
  logic [TYPE_W-1:0] out_type_r;
  logic [DIST_W-1:0] out_dist_r;

  logic              in_xfer;
  logic              out_load;
  logic [SH_W-1:0]   row_div;
  logic [SH_W-1:0]   col_div;
  cell_pos_t         hop_q;
  cell_pos_t         hop_w;

  // One move on the torus, odd-column offset layout
  function automatic cell_pos_t hop_pos(input cell_pos_t p, input logic [SIDE_W-1:0] sd,
                                        input logic [DIM_W-1:0] rows,
                                        input logic [DIM_W-1:0] cols);
    logic [DIM_W-1:0] r_inc;
    logic [DIM_W-1:0] c_inc;
    logic [ROW_W-1:0] up;
    logic [ROW_W-1:0] dn;
    logic [COL_W-1:0] lf;
    logic [COL_W-1:0] rt;
    logic             odd;
    cell_pos_t        q;
    r_inc = {{(DIM_W-ROW_W){1'b0}}, p.row} + DIM_W'(1);
    c_inc = {{(DIM_W-COL_W){1'b0}}, p.col} + DIM_W'(1);
    up    = (r_inc >= rows) ? '0 : r_inc[ROW_W-1:0];
    dn    = (p.row == '0) ? ROW_W'(rows - DIM_W'(1)) : p.row - ROW_W'(1);
    rt    = (c_inc >= cols) ? '0 : c_inc[COL_W-1:0];
    lf    = (p.col == '0) ? COL_W'(cols - DIM_W'(1)) : p.col - COL_W'(1);
    odd   = p.col[0];
    case (sd)
      SIDE_LEFT:  begin q.row = p.row; q.col = lf; end
      SIDE_UP_L:  begin q.row = up;    q.col = odd ? p.col : lf; end
      SIDE_UP_R:  begin q.row = up;    q.col = odd ? rt : p.col; end
      SIDE_RIGHT: begin q.row = p.row; q.col = rt; end
      SIDE_DN_R:  begin q.row = dn;    q.col = odd ? rt : p.col; end
      SIDE_DN_L:  begin q.row = dn;    q.col = odd ? p.col : lf; end
      default:    q = p;   // no side: stay on the cell
    endcase
    return q;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign busy        = (state_r != S_IDLE);

  // Divisor shifted to the current quotient bit
  assign row_div = {{MOD_STEPS{1'b0}}, grid_cfg.rows} << mod_cnt_r;
  assign col_div = {{MOD_STEPS{1'b0}}, grid_cfg.cols} << mod_cnt_r;

  assign hop_q = hop_pos(qpos_r, side_r, grid_cfg.rows, grid_cfg.cols);
  assign hop_w = hop_pos(wpos_r, side_r, grid_cfg.rows, grid_cfg.cols);

  // Memory port: writes straight from the input transfer, reads along the ray
  always_comb begin
    ram_req.wr_en   = in_xfer && (in_ch.op == OP_WRITE)
                      && ({1'b0, in_ch.row} < (ROW_W+1)'(MAX_ROWS))
                      && ({1'b0, in_ch.col} < (COL_W+1)'(MAX_COLS));
    ram_req.wr_addr = {in_ch.row, in_ch.col};   // row * MAX_COLS + col
    ram_req.wr_data = in_ch.cell_type;
    ram_req.rd_en   = (state_r == S_PRIME) || (state_r == S_WALK);
    ram_req.rd_addr = {wpos_r.row, wpos_r.col};
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    mod_cnt_nxt = mod_cnt_r;
    qpos_nxt    = qpos_r;
    side_nxt    = side_r;
    npos_nxt    = npos_r;
    wpos_nxt    = wpos_r;
    step_nxt    = step_r;
    first_nxt   = first_r;
    nb_type_nxt = nb_type_r;
    dist_nxt    = dist_r;
    out_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_ch.op == OP_QUERY)) begin
          qpos_nxt.row = in_ch.row;
          qpos_nxt.col = in_ch.col;
          side_nxt     = in_ch.side;
          mod_cnt_nxt  = MODCNT_W'(MOD_STEPS - 1);
          state_nxt    = S_MOD;
        end
      end
      // Restoring remainder, one quotient bit per cycle for row and column
      S_MOD: begin
        if ({{DIM_W{1'b0}}, qpos_r.row} >= row_div) begin
          qpos_nxt.row = qpos_r.row - row_div[ROW_W-1:0];
        end
        if ({{(SH_W-COL_W){1'b0}}, qpos_r.col} >= col_div) begin
          qpos_nxt.col = qpos_r.col - col_div[COL_W-1:0];
        end
        if (mod_cnt_r == '0) begin
          state_nxt = S_HOP;
        end else begin
          mod_cnt_nxt = mod_cnt_r - MODCNT_W'(1);
        end
      end
      S_HOP: begin
        npos_nxt  = hop_q;
        wpos_nxt  = hop_q;
        state_nxt = S_PRIME;
      end
      // First read is the neighbour itself
      S_PRIME: begin
        wpos_nxt  = hop_w;
        step_nxt  = DIM_W'(1);
        first_nxt = 1'b1;
        state_nxt = S_WALK;
      end
      // Data for step_r arrives; the next cell is already being read
      S_WALK: begin
        first_nxt = 1'b0;
        if (first_r) begin
          nb_type_nxt = ram_rd_data;
        end
        if ((side_r > SIDE_DN_L) || (step_r >= grid_cfg.rows)) begin
          dist_nxt  = '0;
          state_nxt = S_DONE;
        end else if (ram_rd_data == TYPE_NODE) begin
          dist_nxt  = step_r[DIST_W-1:0];
          state_nxt = S_DONE;
        end else if (ram_rd_data == TYPE_EMPTY) begin
          dist_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          wpos_nxt = hop_w;
          step_nxt = step_r + DIM_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mod_cnt_r <= mod_cnt_nxt;
    qpos_r    <= qpos_nxt;
    side_r    <= side_nxt;
    npos_r    <= npos_nxt;
    wpos_r    <= wpos_nxt;
    step_r    <= step_nxt;
    first_r   <= first_nxt;
    nb_type_r <= nb_type_nxt;
    dist_r    <= dist_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r  <= npos_r;
      out_type_r <= nb_type_r;
      out_dist_r <= dist_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.next_row       = out_pos_r.row;
  assign out_ch.next_col       = out_pos_r.col;
  assign out_ch.neighbour_type = out_type_r;
  assign out_ch.node_distance  = out_dist_r;

endmodule

>>> bench/htrd_answer_check.sv
// Result checker for the hex torus ray distance block: tracks the grid size
// and cell contents, predicts every query answer and compares the result channel.
// Depends on htrd_pkg, htrd_in_if and htrd_out_if.
module htrd_answer_check (
  input  logic        clk,
  input  logic        rst_n,
  htrd_in_if          in_mon,
  htrd_out_if         out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatches,
  output int          answers_due,
  output int          answers_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import htrd_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0]  next_row;
    logic [COL_W-1:0]  next_col;
    logic [TYPE_W-1:0] neighbour_type;
    logic [DIST_W-1:0] node_distance;
  } answer_t;

  logic [TYPE_W-1:0] cell_shadow [MAX_ROWS][MAX_COLS];
  int                rows_in_use = MAX_ROWS;
  int                cols_in_use = MAX_COLS;
  answer_t           expected_answers [$];

  initial begin
    foreach (cell_shadow[r, c]) cell_shadow[r][c] = TYPE_EMPTY;
  end

  // Only the low 7 bits count; zero reads as one, oversize saturates
  function automatic int fit_dim(logic [31:0] value, int limit);
    int v;
    v = int'(value[DIM_W-1:0]);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // One move across a hexagon side, odd-column offset layout, wrapping both ways
  function automatic void hex_step(input int r, input int c, input int side,
                                   output int nr, output int nc);
    int up, dn, left, right;
    bit odd;
    up    = (r + 1 >= rows_in_use) ? 0 : r + 1;
    dn    = (r == 0) ? rows_in_use - 1 : r - 1;
    left  = (c == 0) ? cols_in_use - 1 : c - 1;
    right = (c + 1 >= cols_in_use) ? 0 : c + 1;
    odd   = c[0];
    case (side)
      0: begin nr = r;  nc = left; end
      1: begin nr = up; nc = odd ? c : left; end
      2: begin nr = up; nc = odd ? right : c; end
      3: begin nr = r;  nc = right; end
      4: begin nr = dn; nc = odd ? right : c; end
      5: begin nr = dn; nc = odd ? c : left; end
      default: begin nr = r; nc = c; end
    endcase
  endfunction

  // Neighbour on the side plus distance to the first node along that ray
  function automatic answer_t trace_ray(int r, int c, int side);
    int nr, nc, wr, wc, ray_steps, t;
    answer_t a;
    r = r % rows_in_use;
    c = c % cols_in_use;
    hex_step(r, c, side, nr, nc);
    ray_steps = 0;
    if (side < 6) begin
      wr = nr;
      wc = nc;
      for (int step = 1; step < rows_in_use; step++) begin
        t = int'(cell_shadow[wr][wc]);
        if (t == int'(TYPE_NODE)) begin
          ray_steps = step;
          break;
        end
        if (t == int'(TYPE_EMPTY)) break;
        hex_step(wr, wc, side, wr, wc);
      end
    end
    if (ray_steps > 63) ray_steps = 63;
    a.next_row       = nr[ROW_W-1:0];
    a.next_col       = nc[COL_W-1:0];
    a.neighbour_type = cell_shadow[nr][nc];
    a.node_distance  = ray_steps[DIST_W-1:0];
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst_n) begin
      mismatches      = 0;
      answers_due     = 0;
      answers_checked = 0;
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_GRID_ROWS) rows_in_use = fit_dim(cfg_pwdata, MAX_ROWS);
        else cols_in_use = fit_dim(cfg_pwdata, MAX_COLS);
      end

      // result transfer against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.next_row       = out_mon.next_row;
        got.next_col       = out_mon.next_col;
        got.neighbour_type = out_mon.neighbour_type;
        got.node_distance  = out_mon.node_distance;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: unexpected result row %0d col %0d type %0d dist %0d",
                     $time, got.next_row, got.next_col, got.neighbour_type,
                     got.node_distance);
        end else begin
          want = expected_answers.pop_front();
          answers_checked++;
          if (got.next_row !== want.next_row || got.next_col !== want.next_col ||
              got.neighbour_type !== want.neighbour_type ||
              got.node_distance !== want.node_distance) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR %0t: result %0d expected row %0d col %0d type %0d dist %0d,",
                        " got row %0d col %0d type %0d dist %0d"},
                       $time, answers_checked, want.next_row, want.next_col,
                       want.neighbour_type, want.node_distance, got.next_row,
                       got.next_col, got.neighbour_type, got.node_distance);
          end
        end
      end

      // input transfer: writes update the grid, queries queue an answer
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_WRITE)
          cell_shadow[in_mon.row][in_mon.col] = in_mon.cell_type;
        else
          expected_answers.insert(expected_answers.size(),
                                  trace_ray(int'(in_mon.row), int'(in_mon.col),
                                            int'(in_mon.side)));
      end

      answers_due = expected_answers.size();
    end
  end

endmodule

>>> bench/tb_hex_torus_ray_distance_top.sv
// Top of the hex torus ray distance bench: clock, reset, item and register
// stimulus, handshake idling and verdict. Depends on htrd_pkg, the channel
// interfaces, hex_torus_ray_distance_top and htrd_answer_check.
module tb_hex_torus_ray_distance_top;
  timeunit 1ns;
  timeprecision 1ps;
  import htrd_pkg::*;

  localparam int SETTLE_CYCLES = 100;  // beyond the worst query
  localparam int RANDOM_ITEMS  = 60;   // per grid setting
  localparam int NUM_SETTINGS  = 6;
  localparam int ROW_SETS [NUM_SETTINGS] = '{64, 0, 127, 13, 2, 0};
  localparam int COL_SETS [NUM_SETTINGS] = '{4, 127, 0, 6, 3, 0};
  localparam logic [TYPE_W-1:0] TYPE_OTHER = 2'd3;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          items_sent = 0;
  int          grid_rows = MAX_ROWS;   // grid size in use, after clamping
  int          grid_cols = MAX_COLS;
  int          mismatches, answers_due, answers_checked;

  htrd_in_if  in_ch ();
  htrd_out_if out_ch ();

  hex_torus_ray_distance_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  htrd_answer_check answer_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .mismatches      (mismatches),
    .answers_due     (answers_due),
    .answers_checked (answers_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("hex_torus_ray_distance_top test failed");
    $finish;
  end

  // One item transfer, with random idle cycles ahead of it
  task automatic push_item(logic op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [SIDE_W-1:0] side, logic [TYPE_W-1:0] ty);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.row       <= row;
    in_ch.col       <= col;
    in_ch.side      <= side;
    in_ch.cell_type <= ty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Register write: setup then access; upper bits sometimes carry junk
  task automatic write_reg(logic idx, int value);
    logic [31:0] data;
    data = 32'(value);
    if ($urandom_range(1) == 1) data = data | ($urandom() & 32'hFFFF_FF80);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drop valid, drain outstanding answers, then give the walker time to go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (answers_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Grid size the block uses for a raw register value
  function automatic int fit_dim(int value, int limit);
    int v;
    v = value & 127;
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // Mostly edge-like cells so rays run long; percentages for node and empty
  function automatic logic [TYPE_W-1:0] pick_type(int node_pct, int empty_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < node_pct) return TYPE_NODE;
    if (roll < node_pct + empty_pct) return TYPE_EMPTY;
    return ($urandom_range(1) == 1) ? TYPE_EDGE : TYPE_OTHER;
  endfunction

  // Write every cell of the grid in use so no query ever reads an unwritten cell
  task automatic fill_grid(int node_pct, int empty_pct);
    for (int r = 0; r < grid_rows; r++)
      for (int c = 0; c < grid_cols; c++)
        push_item(OP_WRITE, r[ROW_W-1:0], c[COL_W-1:0], SIDE_W'($urandom_range(7)),
                  pick_type(node_pct, empty_pct));
  endtask

  // Directed cases on a 64x4 grid of edge-like cells
  task automatic corner_cases();
    push_item(OP_WRITE, 6'd63, 6'd1, 3'd7, TYPE_NODE);
    push_item(OP_WRITE, 6'd5, 6'd0, 3'd0, TYPE_EMPTY);
    push_item(OP_WRITE, 6'd10, 6'd2, 3'd5, TYPE_OTHER);
    // node reached on the very last allowed step, straight up an odd column
    push_item(OP_QUERY, 6'd0, 6'd1, 3'd1, TYPE_OTHER);
    // same node one step away, wrapping down from row 0
    push_item(OP_QUERY, 6'd0, 6'd1, 3'd5, TYPE_EDGE);
    // empty cell on the second step stops the walk
    push_item(OP_QUERY, 6'd3, 6'd0, 3'd2, TYPE_EDGE);
    // neighbour of type three, walk continues through it
    push_item(OP_QUERY, 6'd10, 6'd3, 3'd0, TYPE_EMPTY);
    // every side code from the origin, even column, wrapping down and left
    for (int s = 0; s < 8; s++)
      push_item(OP_QUERY, 6'd0, 6'd0, s[SIDE_W-1:0], TYPE_EDGE);
    // odd column at the far corner, wrapping up and right
    push_item(OP_QUERY, 6'd63, 6'd3, 3'd1, TYPE_NODE);
    push_item(OP_QUERY, 6'd63, 6'd3, 3'd2, TYPE_EMPTY);
    push_item(OP_QUERY, 6'd63, 6'd3, 3'd4, TYPE_OTHER);
    push_item(OP_QUERY, 6'd63, 6'd3, 3'd5, TYPE_EDGE);
    // column outside the grid is reduced first
    push_item(OP_QUERY, 6'd20, 6'd62, 3'd3, TYPE_EDGE);
  endtask

  // Random mix of queries and cell updates; most writes land inside the grid
  task automatic random_traffic(int count);
    int wr_row, wr_col;
    repeat (count) begin
      if ($urandom_range(99) < 55) begin
        push_item(OP_QUERY, ROW_W'($urandom_range(63)), COL_W'($urandom_range(63)),
                  SIDE_W'($urandom_range(7)), TYPE_W'($urandom_range(3)));
      end else begin
        if ($urandom_range(99) < 80) begin
          wr_row = $urandom_range(grid_rows - 1);
          wr_col = $urandom_range(grid_cols - 1);
        end else begin
          wr_row = $urandom_range(63);
          wr_col = $urandom_range(63);
        end
        push_item(OP_WRITE, ROW_W'(wr_row), COL_W'(wr_col),
                  SIDE_W'($urandom_range(7)), pick_type(15, 10));
      end
    end
  endtask

  initial begin
    int rows_val, cols_val;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_WRITE;
    in_ch.row       = '0;
    in_ch.col       = '0;
    in_ch.side      = '0;
    in_ch.cell_type = TYPE_EMPTY;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Three idling mixes, two grid settings each
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s == 0) begin
        send_idle = 18;
        recv_idle = 71;
      end else if (s == 2) begin
        send_idle = 71;
        recv_idle = 18;
      end else if (s == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (s > 0) settle();
      rows_val = (s == NUM_SETTINGS - 1) ? $urandom_range(1, MAX_ROWS) : ROW_SETS[s];
      cols_val = (s == NUM_SETTINGS - 1) ? $urandom_range(1, 4) : COL_SETS[s];
      write_reg(REG_GRID_ROWS, rows_val);
      write_reg(REG_GRID_COLS, cols_val);
      grid_rows = fit_dim(rows_val, MAX_ROWS);
      grid_cols = fit_dim(cols_val, MAX_COLS);
      if (s == 0) begin
        fill_grid(0, 0);
        corner_cases();
      end else begin
        fill_grid(8, 5);
      end
      random_traffic(RANDOM_ITEMS);
    end
    in_ch.valid <= 1'b0;

    while (answers_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d items over %0d grid sizes and three idle mixes (grid fills included).",
             items_sent, NUM_SETTINGS);
    $display("Checked %0d query results, %0d mismatches.", answers_checked, mismatches);
    if (mismatches == 0) begin
      $display("hex_torus_ray_distance_top test passed");
    end else begin
      $display("hex_torus_ray_distance_top test failed");
    end
    $finish;
  end

endmodule
